@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and helpers of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ID_W   = 8;
	localparam int CNT_W  = 9;
	localparam int OFS_W  = 24;
	localparam int BSL_W  = 5;
	localparam logic [BSL_W-1:0] SH_MAX = 5'd16;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic REG_POOL_BLOCKS     = 1'b0;
	localparam logic REG_BLOCK_SIZE_LOG2 = 1'b1;

	typedef struct packed {
		logic             pool_wr;
		logic [CNT_W-1:0] pool_wdata;
		logic [CNT_W-1:0] pool_blocks;
		logic [BSL_W-1:0] block_size_log2;
	} cfg_t;

	function automatic logic [CNT_W-1:0] eff_pool(logic [CNT_W-1:0] v, logic [CNT_W-1:0] lim);
		logic [CNT_W-1:0] n;
		n = v;
		if (n == '0)
			n = 9'd1;
		if (n > lim)
			n = lim;
		return n;
	endfunction

endpackage

@@ src/fixed_block_pool_allocator.sv @@
// A request is held in stage 1; its result is registered in m_tdata once the output is free.
// Requests do not overlap: the next is taken once the last has read and written the stack.
// A waiting result does not block the next request; a second one holds until it is taken.
// Reset: asynchronous, active low; the pool is empty of allocations, size 256, block 64 bytes.
// Writing pool_blocks empties the pool at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// LIFO free-list allocator of equal power-of-two blocks with error status.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] block_id
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [1:0] status, [9:2] granted_id,
	                               // [33:10] data_ofs, [42:34] free_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fbpa_pkg::*;

	localparam int LIM = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
	localparam int AW  = $clog2(LIM);
	localparam logic [CNT_W-1:0] LIM_N = CNT_W'(LIM);

	cfg_t cfg;

	fbpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [ID_W-1:0]  stack_mem [LIM];
	logic             use_mem [LIM];
	logic [LIM-1:0]   vld_q;

	logic [CNT_W-1:0] depth_q, fresh_q, used_q;
	logic             s1_valid_q, func_s1;
	logic [ID_W-1:0]  id_s1, stk_rd_s1;
	logic             use_rd_s1, vld_rd_s1;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;

	logic             s_fire, ex;
	logic [AW-1:0]    stk_raddr, id_idx;
	logic [CNT_W-1:0] n, depth_d, fresh_d, used_d, fc;
	logic [ID_W-1:0]  granted;
	logic [OFS_W-1:0] ofs;
	logic [BSL_W-1:0] sh;
	status_t          status;
	logic             in_use, stk_we, use_we, use_wdata;
	logic [AW-1:0]    use_waddr;

	assign s_tready  = !s1_valid_q;
	assign s_fire    = s_tvalid & s_tready;
	assign ex        = s1_valid_q & (!m_tvalid_q | m_tready);
	assign stk_raddr = AW'(depth_q - 9'd1);
	assign id_idx    = s_tdata[AW-1:0];
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		n         = eff_pool(cfg.pool_blocks, LIM_N);
		in_use    = use_rd_s1 & vld_rd_s1;
		depth_d   = depth_q;
		fresh_d   = fresh_q;
		used_d    = used_q;
		granted   = '0;
		status    = ST_OK;
		stk_we    = 1'b0;
		use_we    = 1'b0;
		use_wdata = 1'b0;
		use_waddr = id_s1[AW-1:0];
		if (func_s1 == FUNC_ALLOC) begin
			if (depth_q != '0) begin
				depth_d = depth_q - 9'd1;
				granted = stk_rd_s1;
			end else if (fresh_q != '0) begin
				fresh_d = fresh_q - 9'd1;
				granted = fresh_d[ID_W-1:0];
			end else begin
				status = ST_EMPTY;
			end
			if (status == ST_OK) begin
				used_d    = used_q + 9'd1;
				use_we    = 1'b1;
				use_wdata = 1'b1;
				use_waddr = granted[AW-1:0];
			end
		end else begin
			if (({1'b0, id_s1} >= n) || !in_use || (32'(depth_q) >= MAX_BLOCKS)) begin
				status = ST_BAD_FREE;
			end else begin
				stk_we  = 1'b1;
				use_we  = 1'b1;
				depth_d = depth_q + 9'd1;
				if (used_q != '0)
					used_d = used_q - 9'd1;
			end
		end
		sh  = (cfg.block_size_log2 > SH_MAX) ? SH_MAX : cfg.block_size_log2;
		ofs = OFS_W'(granted) << sh;
		fc  = (used_d <= n) ? (n - used_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			depth_q    <= '0;
			fresh_q    <= LIM_N;
			used_q     <= '0;
			vld_q      <= '0;
		end else begin
			if (cfg.pool_wr) begin
				depth_q <= '0;
				used_q  <= '0;
				fresh_q <= eff_pool(cfg.pool_wdata, LIM_N);
				vld_q   <= '0;
			end else if (ex) begin
				depth_q <= depth_d;
				fresh_q <= fresh_d;
				used_q  <= used_d;
				if (use_we)
					vld_q[use_waddr] <= 1'b1;
			end
			if (s_fire)
				s1_valid_q <= 1'b1;
			else if (ex)
				s1_valid_q <= 1'b0;
			if (ex)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_s1   <= s_tuser;
			id_s1     <= s_tdata;
			stk_rd_s1 <= stack_mem[stk_raddr];
			use_rd_s1 <= use_mem[id_idx];
			vld_rd_s1 <= vld_q[id_idx];
		end
		if (ex && stk_we)
			stack_mem[depth_q[AW-1:0]] <= id_s1;
		if (ex && use_we)
			use_mem[use_waddr] <= use_wdata;
		if (ex)
			m_tdata_q <= {5'd0, fc, ofs, granted, status};
	end

`ifndef SYNTH
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(10'(depth_q) + 10'(fresh_q) + 10'(used_q)) == 10'(n))
		else $error("free and used counts do not add up to the pool size");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("request taken while another is in flight");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ex && func_s1 == FUNC_ALLOC && status == ST_OK) |-> ({1'b0, granted} < n))
		else $error("granted block outside the pool");

	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ex && func_s1 == FUNC_FREE && status == ST_OK && !cfg.pool_wr)
		|=> used_q == $past(used_q) - 9'd1)
		else $error("used count not decremented on free");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		ex |=> m_tvalid)
		else $error("executed request produced no result");
`endif

endmodule

@@ src/fbpa_cfg.sv @@
// ----------------------------------------------------------------------------
// fbpa_cfg
// Register block of the pool allocator: pool size and block size log2.
// ----------------------------------------------------------------------------
module fbpa_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output fbpa_pkg::cfg_t    cfg
);
	import fbpa_pkg::*;

	logic [CNT_W-1:0] pool_q;
	logic [BSL_W-1:0] bsl_q;
	logic             wr;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr      = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 9'd256;
			bsl_q  <= 5'd6;
		end else if (wr) begin
			case (reg_sel)
				REG_POOL_BLOCKS:     pool_q <= pwdata[CNT_W-1:0];
				REG_BLOCK_SIZE_LOG2: bsl_q  <= pwdata[BSL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_POOL_BLOCKS:     prdata = {23'd0, pool_q};
			REG_BLOCK_SIZE_LOG2: prdata = {27'd0, bsl_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.pool_wr         = wr & (reg_sel == REG_POOL_BLOCKS);
	assign cfg.pool_wdata      = pwdata[CNT_W-1:0];
	assign cfg.pool_blocks     = pool_q;
	assign cfg.block_size_log2 = bsl_q;

endmodule

@@ sim/fixed_block_pool_allocator_test.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Checks allocate and free requests against a shadow pool: LIFO reuse of
// returned blocks, fresh numbering from the top, offsets, empty-pool and
// bad-free status and free counts, across pool sizes and block sizes with
// random stalls on both stream sides.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;

	import fbpa_pkg::*;

	localparam int SHADOW_GEN = 0;
	localparam int SHADOW_CHK = 1;
	localparam int POOL_LIM   = 256;
	localparam int LIMIT      = 400000;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 96;

	typedef struct packed {
		logic             func;
		logic [ID_W-1:0]  block_id;
	} pool_req_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  granted;
		logic [OFS_W-1:0] offset;
		logic [CNT_W-1:0] free_count;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] block_id
	logic        s_tuser = 1'b0;  // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // [1:0] status, [9:2] granted_id,
	                              // [33:10] data_ofs, [42:34] free_count
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fixed_block_pool_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// two copies of the pool: one steered by the stimulus, one by accepted requests
	logic [ID_W-1:0]  ret_stack [2][POOL_LIM];
	logic [CNT_W-1:0] ret_depth [2];
	logic [CNT_W-1:0] fresh_next [2];
	logic             in_use [2][POOL_LIM];
	logic [CNT_W-1:0] used_cnt [2];
	logic [CNT_W-1:0] pool_reg [2];
	logic [BSL_W-1:0] shift_reg [2];

	pool_req_t request_queue [$];
	grant_t    grant_expect [$];
	int        errors = 0;
	int        cycles = 0;
	int        send_idle_pct = 27;
	int        recv_idle_pct = 63;
	bit        req_taken = 1'b0;

	function automatic logic [CNT_W-1:0] pool_size(int c);
		logic [CNT_W-1:0] n;
		n = pool_reg[c];
		if (n == '0)
			n = 9'd1;
		if (n > POOL_LIM)
			n = CNT_W'(POOL_LIM);
		return n;
	endfunction

	function automatic void pool_clear(int c);
		for (int i = 0; i < POOL_LIM; i++)
			in_use[c][i] = 1'b0;
		ret_depth[c] = '0;
		used_cnt[c]  = '0;
		fresh_next[c] = pool_size(c);
	endfunction

	function automatic void pool_write(int c, logic reg_idx, logic [31:0] value);
		if (reg_idx == REG_POOL_BLOCKS) begin
			pool_reg[c] = value[CNT_W-1:0];
			pool_clear(c);
		end else begin
			shift_reg[c] = value[BSL_W-1:0];
		end
	endfunction

	function automatic grant_t pool_step(int c, logic func, logic [ID_W-1:0] id);
		grant_t           r;
		logic [CNT_W-1:0] n;
		logic [31:0]      wide;
		logic [4:0]       sh;
		logic             got;
		n = pool_size(c);
		r = '{status: ST_OK, granted: '0, offset: '0, free_count: '0};
		got = 1'b0;
		if (func == FUNC_ALLOC) begin
			if (ret_depth[c] > 0) begin
				ret_depth[c] = ret_depth[c] - 9'd1;
				r.granted = ret_stack[c][ret_depth[c]];
				got = 1'b1;
			end else if (fresh_next[c] > 0) begin
				fresh_next[c] = fresh_next[c] - 9'd1;
				r.granted = fresh_next[c][ID_W-1:0];
				got = 1'b1;
			end
			if (got) begin
				sh = (shift_reg[c] > 16) ? 5'd16 : shift_reg[c];
				in_use[c][r.granted] = 1'b1;
				used_cnt[c] = used_cnt[c] + 9'd1;
				wide = {24'b0, r.granted} << sh;
				r.offset = wide[OFS_W-1:0];
			end else begin
				r.status = ST_EMPTY;
			end
		end else begin
			if ({1'b0, id} >= n || !in_use[c][id] || ret_depth[c] >= POOL_LIM) begin
				r.status = ST_BAD_FREE;
			end else begin
				in_use[c][id] = 1'b0;
				ret_stack[c][ret_depth[c]] = id;
				ret_depth[c] = ret_depth[c] + 9'd1;
				if (used_cnt[c] > 0)
					used_cnt[c] = used_cnt[c] - 9'd1;
			end
		end
		r.free_count = (used_cnt[c] <= n) ? n - used_cnt[c] : '0;
		return r;
	endfunction

	function automatic void post(logic func, logic [ID_W-1:0] id);
		grant_t unused;
		request_queue.push_back('{func: func, block_id: id});
		unused = pool_step(SHADOW_GEN, func, id);
	endfunction

	function automatic int pick_live();
		int start;
		int idx;
		start = $urandom_range(POOL_LIM - 1);
		for (int k = 0; k < POOL_LIM; k++) begin
			idx = (start + k) % POOL_LIM;
			if (in_use[SHADOW_GEN][idx])
				return idx;
		end
		return -1;
	endfunction

	function automatic logic [31:0] pick_pool();
		case ($urandom_range(7))
			0: return 0;
			1: return 1;
			2: return $urandom_range(2, 8);
			3: return 256;
			4: return $urandom_range(257, 511);
			5: return 511;
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	function automatic logic [31:0] pick_shift();
		case ($urandom_range(5))
			0: return 0;
			1: return 16;
			2: return 31;
			default: return $urandom_range(0, 31);
		endcase
	endfunction

	task automatic wait_drained();
		while (request_queue.size() != 0 || s_tvalid || grant_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic reg_idx, logic [31:0] value);
		wait_drained();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pool_write(SHADOW_CHK, reg_idx, value);
		pool_write(SHADOW_GEN, reg_idx, value);
	endtask

	task automatic report(string what, grant_t want, grant_t got);
		errors++;
		if (errors <= 10) begin
			$write("%s: expected status %0d id %0d offset %0h free %0d, ",
				what, want.status, want.granted, want.offset, want.free_count);
			$display("got status %0d id %0d offset %0h free %0d",
				got.status, got.granted, got.offset, got.free_count);
		end
	endtask

	// driver: advance to the next request once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tuser  <= request_queue[0].func;
				s_tdata  <= request_queue[0].block_id;
				void'(request_queue.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		grant_t got;
		grant_t want;
		cycles <= cycles + 1;
		req_taken <= s_tvalid && s_tready;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status     = status_t'(m_tdata[1:0]);
				got.granted    = m_tdata[9:2];
				got.offset     = m_tdata[33:10];
				got.free_count = m_tdata[42:34];
				if (grant_expect.size() == 0) begin
					report("unexpected result", '0, got);
				end else begin
					want = grant_expect.pop_front();
					if (got.status != want.status || got.granted != want.granted
						|| got.offset != want.offset || got.free_count != want.free_count)
						report("result mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready)
				grant_expect.push_back(pool_step(SHADOW_CHK, s_tuser, s_tdata));
		end
	end

	initial begin
		int live;
		int alloc_pct;
		int r;
		for (int c = 0; c < 2; c++) begin
			pool_reg[c]  = 9'd256;
			shift_reg[c] = 5'd6;
			pool_clear(c);
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: fresh grants from the top, LIFO reuse, bad and double free
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_ALLOC, 8'hFF);
		post(FUNC_FREE, 8'd255);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_FREE, 8'd0);
		post(FUNC_FREE, 8'd254);
		post(FUNC_FREE, 8'd254);
		post(FUNC_FREE, 8'd255);
		post(FUNC_ALLOC, 8'h5A);

		// single block: empty pool, out of range free
		configure(REG_POOL_BLOCKS, 1);
		configure(REG_BLOCK_SIZE_LOG2, 0);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_FREE, 8'd1);
		post(FUNC_FREE, 8'd255);
		post(FUNC_FREE, 8'd0);
		post(FUNC_FREE, 8'd0);
		post(FUNC_ALLOC, 8'hFF);

		// zero pool acts as one block, oversize shift clamps
		configure(REG_POOL_BLOCKS, 0);
		configure(REG_BLOCK_SIZE_LOG2, 31);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_FREE, 8'd0);

		// oversize pool clamps to 256, largest offset
		configure(REG_POOL_BLOCKS, 511);
		configure(REG_BLOCK_SIZE_LOG2, 16);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_FREE, 8'd255);
		post(FUNC_ALLOC, 8'h00);
		post(FUNC_FREE, 8'd170);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0 || $urandom_range(99) < 70)
				configure(REG_POOL_BLOCKS, pick_pool());
			configure(REG_BLOCK_SIZE_LOG2, pick_shift());
			case (ph / 4)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			alloc_pct = $urandom_range(30, 75);
			for (int k = 0; k < PHASE_LEN; k++) begin
				r = $urandom_range(99);
				live = pick_live();
				if (r < 10)
					post(logic'($urandom_range(1)), ID_W'($urandom_range(255)));
				else if ($urandom_range(99) < alloc_pct || live < 0)
					post(FUNC_ALLOC, ID_W'($urandom_range(255)));
				else
					post(FUNC_FREE, ID_W'(live));
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
